[rtl/assert_macros.svh]
// assertion macros shared by the allocator rtl
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define FFHA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition in one cycle implies a consequence in the next cycle
`define FFHA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/ffha_pkg.sv]
// shared types, constants and codes for the first-fit heap allocator
// no dependencies
`default_nettype none

package ffha_pkg;

  localparam int unsigned ARENA_BYTES   = 4096;
  localparam int unsigned HEADER_BYTES  = 12;
  localparam int unsigned GRANULE_BYTES = 4;
  localparam int unsigned ALIGN_BYTES   = 4;
  localparam int unsigned MAP_DEPTH     = (ARENA_BYTES + GRANULE_BYTES - 1) / GRANULE_BYTES;
  localparam int unsigned GRAN_SHIFT    = $clog2(GRANULE_BYTES);

  // granule index, and scan index that also reaches the arena end
  localparam int unsigned GW  = $clog2(MAP_DEPTH);
  localparam int unsigned IW  = GW + 1;
  // byte offsets, request and rounded size widths
  localparam int unsigned AW  = 13;
  localparam int unsigned RW  = 16;
  localparam int unsigned SZW = RW + 1;
  localparam int unsigned NW  = SZW + 1;

  typedef logic [1:0] map_t;
  localparam map_t MAP_NONE     = 2'b00;
  localparam map_t MAP_START    = 2'b01;
  localparam map_t MAP_USED_BLK = 2'b11;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e            command;
    logic [RW-1:0]   request_bytes;
    logic [AW-1:0]   block_address;
  } cmd_t;

  typedef struct packed {
    logic            granted;
    logic [AW-1:0]   payload_address;
    logic [31:0]     used_blocks;
    logic [31:0]     used_bytes;
  } res_t;

  // span evaluation of one block
  typedef struct packed {
    logic            fit;
    logic            split;
    logic [AW-1:0]   span;
    logic [GW-1:0]   cut_gran;
  } span_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_A_SCAN,
    ST_A_WCUT,
    ST_A_WHDR,
    ST_F_CHK,
    ST_F_FWD,
    ST_F_NXTW,
    ST_F_BWD,
    ST_F_WHDR
  } state_e;

endpackage

`default_nettype wire

[rtl/ffha_map_ram.sv]
// single write port, single registered read port ram for the granule map
// no dependencies
`default_nettype none

module ffha_map_ram #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned Width = 2
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[rtl/ffha_span_unit.sv]
// shared span unit: block size in bytes, fit and split tests, split point
// depends on ffha_pkg
`default_nettype none

module ffha_span_unit import ffha_pkg::*; (
  input  wire logic [GW-1:0]  lo_gran_i,
  input  wire logic [IW-1:0]  hi_idx_i,
  input  wire logic [SZW-1:0] size_i,
  output span_t               res_o
);

  logic [AW-1:0] lo_bytes;
  logic [AW-1:0] hi_bytes;
  logic [AW-1:0] span;
  logic [NW-1:0] cut_bytes;

  always_comb begin
    lo_bytes  = AW'(lo_gran_i) << GRAN_SHIFT;
    hi_bytes  = (hi_idx_i == IW'(MAP_DEPTH)) ? AW'(ARENA_BYTES)
                                             : (AW'(hi_idx_i) << GRAN_SHIFT);
    span      = hi_bytes - lo_bytes;
    cut_bytes = NW'(lo_bytes) + NW'(HEADER_BYTES) + NW'(size_i);

    res_o.span     = span;
    res_o.fit      = NW'(span) >= (NW'(size_i) + NW'(HEADER_BYTES));
    res_o.split    = (NW'(span) > (NW'(size_i) + NW'(2 * HEADER_BYTES)))
                     && ((cut_bytes % GRANULE_BYTES) == '0);
    res_o.cut_gran = GW'(cut_bytes / GRANULE_BYTES);
  end

endmodule

`default_nettype wire

[rtl/first_fit_heap_allocator.sv]
// first-fit heap allocator over a 4096-byte arena, top level; uses ffha_pkg,
// ffha_map_ram, ffha_span_unit. after reset a clearing pass writes the whole map, busy high.
// allocate: scans the map one granule per cycle through the map read port.
// free: a forward walk to the successor and a backward walk to the predecessor cover
// the map once; a free with a bad address is answered straight from idle. the result
// strobe follows the last cycle of a transaction and cannot be stalled; one at a time.
`default_nettype none

`include "assert_macros.svh"

module first_fit_heap_allocator import ffha_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start,
  output logic      busy,
  input  wire cmd_t cmd_i,
  output logic      done_o,
  output res_t      res_o
);

  // sequencer state
  state_e         state_q, state_d;
  // scan read pipeline: next index to read and the read now returning
  logic [IW-1:0]  iss_idx_q, iss_idx_d;
  logic           pend_q, pend_d;
  logic [IW-1:0]  pend_idx_q, pend_idx_d;
  // allocate walk
  logic [GW-1:0]  cur_start_q, cur_start_d;
  logic           cur_used_q, cur_used_d;
  logic           have_blk_q, have_blk_d;
  logic [SZW-1:0] size_q, size_d;
  logic           split_q, split_d;
  logic [GW-1:0]  cut_q, cut_d;
  // free walk
  logic [GW-1:0]  g_q, g_d;
  logic [AW-1:0]  span_q, span_d;
  logic [GW-1:0]  nxt_q, nxt_d;
  logic           nxt_free_q, nxt_free_d;
  logic           prev_free_q, prev_free_d;
  // clearing pass
  logic [GW-1:0]  clr_idx_q, clr_idx_d;
  // counters and result
  logic [31:0]    blk_cnt_q, blk_cnt_d;
  logic [31:0]    byte_cnt_q, byte_cnt_d;
  logic           done_q, done_d;
  res_t           res_q, res_d;

  // map ram
  logic           ram_we;
  logic [GW-1:0]  ram_waddr;
  map_t           ram_wdata;
  logic           ram_re;
  logic [GW-1:0]  ram_raddr;
  map_t           ram_rdata;

  // span unit
  logic [GW-1:0]  su_lo;
  span_t          su_res;

  // decoded scan data; the arena end acts as one more block start
  logic           at_end;
  logic           d_start;
  logic           d_used;

  // free address checks
  logic [AW-1:0]  fr_start;
  logic [IW-1:0]  fr_gran;
  logic           fr_bad;

  // allocate size rounding
  logic [SZW-1:0] req_up;

  // finish of a transaction
  logic           fin;
  logic           fin_granted;
  logic [AW-1:0]  fin_payload;

  ffha_map_ram #(
    .Depth(MAP_DEPTH),
    .Width(2)
  ) u_map_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  ffha_span_unit u_span (
    .lo_gran_i(su_lo),
    .hi_idx_i (pend_idx_q),
    .size_i   (size_q),
    .res_o    (su_res)
  );

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

  assign at_end  = (pend_idx_q == IW'(MAP_DEPTH));
  assign d_start = at_end | ram_rdata[0];
  assign d_used  = !at_end & ram_rdata[1];

  // free walk measures from the freed header, allocate from the current block
  assign su_lo = (state_q == ST_F_FWD) ? g_q : cur_start_q;

  assign fr_start = cmd_i.block_address - AW'(HEADER_BYTES);
  assign fr_gran  = IW'(fr_start / GRANULE_BYTES);
  assign fr_bad   = (cmd_i.block_address < AW'(HEADER_BYTES))
                    || (cmd_i.block_address > AW'(ARENA_BYTES))
                    || ((fr_start % GRANULE_BYTES) != '0)
                    || (fr_gran >= IW'(MAP_DEPTH));

  assign req_up = (SZW'(cmd_i.request_bytes) + SZW'(ALIGN_BYTES - 1))
                  & ~SZW'(ALIGN_BYTES - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_idx_q  <= '0;
      pend_q     <= 1'b0;
      blk_cnt_q  <= '0;
      byte_cnt_q <= 32'(HEADER_BYTES);
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_idx_q  <= clr_idx_d;
      pend_q     <= pend_d;
      blk_cnt_q  <= blk_cnt_d;
      byte_cnt_q <= byte_cnt_d;
      done_q     <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    iss_idx_q   <= iss_idx_d;
    pend_idx_q  <= pend_idx_d;
    cur_start_q <= cur_start_d;
    cur_used_q  <= cur_used_d;
    have_blk_q  <= have_blk_d;
    size_q      <= size_d;
    split_q     <= split_d;
    cut_q       <= cut_d;
    g_q         <= g_d;
    span_q      <= span_d;
    nxt_q       <= nxt_d;
    nxt_free_q  <= nxt_free_d;
    prev_free_q <= prev_free_d;
    res_q       <= res_d;
  end

  always_comb begin
    state_d     = state_q;
    iss_idx_d   = iss_idx_q;
    pend_d      = 1'b0;
    pend_idx_d  = iss_idx_q;
    cur_start_d = cur_start_q;
    cur_used_d  = cur_used_q;
    have_blk_d  = have_blk_q;
    size_d      = size_q;
    split_d     = split_q;
    cut_d       = cut_q;
    g_d         = g_q;
    span_d      = span_q;
    nxt_d       = nxt_q;
    nxt_free_d  = nxt_free_q;
    prev_free_d = prev_free_q;
    clr_idx_d   = clr_idx_q;
    blk_cnt_d   = blk_cnt_q;
    byte_cnt_d  = byte_cnt_q;
    done_d      = 1'b0;
    res_d       = res_q;

    ram_we      = 1'b0;
    ram_waddr   = clr_idx_q;
    ram_wdata   = MAP_NONE;
    ram_re      = 1'b0;
    ram_raddr   = iss_idx_q[GW-1:0];

    fin         = 1'b0;
    fin_granted = 1'b0;
    fin_payload = '0;

    // forward scan reads one granule a cycle up to the arena end
    if ((state_q inside {ST_A_SCAN, ST_F_CHK, ST_F_FWD})
        && (iss_idx_q <= IW'(MAP_DEPTH))) begin
      ram_re     = (iss_idx_q != IW'(MAP_DEPTH));
      pend_d     = 1'b1;
      pend_idx_d = iss_idx_q;
      iss_idx_d  = iss_idx_q + IW'(1);
    end

    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_idx_q;
        ram_wdata = (clr_idx_q == '0) ? MAP_START : MAP_NONE;
        clr_idx_d = clr_idx_q + GW'(1);
        if (clr_idx_q == GW'(MAP_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (start) begin
          if (cmd_i.command == CMD_ALLOC) begin
            size_d     = req_up;
            iss_idx_d  = '0;
            have_blk_d = 1'b0;
            state_d    = ST_A_SCAN;
          end else if (fr_bad) begin
            // bad free address: counters stay, result right away
            fin = 1'b1;
          end else begin
            g_d        = fr_gran[GW-1:0];
            ram_re     = 1'b1;
            ram_raddr  = fr_gran[GW-1:0];
            pend_d     = 1'b1;
            pend_idx_d = fr_gran;
            iss_idx_d  = fr_gran + IW'(1);
            state_d    = ST_F_CHK;
          end
        end
      end

      ST_A_SCAN: begin
        if (pend_q && d_start) begin
          if (have_blk_q && !cur_used_q && su_res.fit) begin
            split_d = su_res.split;
            cut_d   = su_res.cut_gran;
            state_d = ST_A_WCUT;
          end else if (at_end) begin
            // no free block fits
            fin     = 1'b1;
            state_d = ST_IDLE;
          end else begin
            cur_start_d = pend_idx_q[GW-1:0];
            cur_used_d  = d_used;
            have_blk_d  = 1'b1;
          end
        end
      end

      ST_A_WCUT: begin
        if (split_q) begin
          ram_we    = 1'b1;
          ram_waddr = cut_q;
          ram_wdata = MAP_START;
        end
        state_d = ST_A_WHDR;
      end

      ST_A_WHDR: begin
        ram_we      = 1'b1;
        ram_waddr   = cur_start_q;
        ram_wdata   = MAP_USED_BLK;
        blk_cnt_d   = blk_cnt_q + 32'd1;
        byte_cnt_d  = byte_cnt_q + 32'(size_q)
                      + (split_q ? 32'(HEADER_BYTES) : 32'd0);
        fin         = 1'b1;
        fin_granted = 1'b1;
        fin_payload = (AW'(cur_start_q) << GRAN_SHIFT) + AW'(HEADER_BYTES);
        state_d     = ST_IDLE;
      end

      ST_F_CHK: begin
        // header must be the start of a used block
        if (ram_rdata != MAP_USED_BLK) begin
          fin     = 1'b1;
          state_d = ST_IDLE;
        end else begin
          state_d = ST_F_FWD;
        end
      end

      ST_F_FWD: begin
        if (pend_q && d_start) begin
          span_d     = su_res.span;
          nxt_d      = pend_idx_q[GW-1:0];
          nxt_free_d = !at_end && !ram_rdata[1];
          iss_idx_d  = IW'(g_q) - IW'(1);
          state_d    = ST_F_NXTW;
        end
      end

      ST_F_NXTW: begin
        // merge a free successor by dropping its start mark
        if (nxt_free_q) begin
          ram_we    = 1'b1;
          ram_waddr = nxt_q;
          ram_wdata = MAP_NONE;
        end
        if (g_q == '0) begin
          prev_free_d = 1'b0;
          state_d     = ST_F_WHDR;
        end else begin
          ram_re     = 1'b1;
          pend_d     = 1'b1;
          pend_idx_d = iss_idx_q;
          iss_idx_d  = iss_idx_q - IW'(1);
          state_d    = ST_F_BWD;
        end
      end

      ST_F_BWD: begin
        // walk back one granule a cycle to the predecessor start
        ram_re     = 1'b1;
        pend_d     = 1'b1;
        pend_idx_d = iss_idx_q;
        iss_idx_d  = iss_idx_q - IW'(1);
        if (pend_q) begin
          if (ram_rdata[0]) begin
            prev_free_d = !ram_rdata[1];
            state_d     = ST_F_WHDR;
          end else if (pend_idx_q == '0) begin
            prev_free_d = 1'b0;
            state_d     = ST_F_WHDR;
          end
        end
      end

      ST_F_WHDR: begin
        ram_we     = 1'b1;
        ram_waddr  = g_q;
        ram_wdata  = prev_free_q ? MAP_NONE : MAP_START;
        blk_cnt_d  = blk_cnt_q - 32'd1;
        byte_cnt_d = byte_cnt_q - 32'(span_q);
        fin        = 1'b1;
        state_d    = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // result transaction, counters taken after this command's update
    if (fin) begin
      done_d                = 1'b1;
      res_d.granted         = fin_granted;
      res_d.payload_address = fin_payload;
      res_d.used_blocks     = blk_cnt_d;
      res_d.used_bytes      = byte_cnt_d;
    end
  end

  // an accepted transaction either keeps the block busy or reports at once
  `FFHA_ASSERT_NEXT(a_accept_progress, clk_i, rst_ni, start && !busy, busy || done_o, "accepted transaction neither busy nor done")
  // a granted result follows the header write of an allocation
  `FFHA_ASSERT_NEXT(a_alloc_reports, clk_i, rst_ni, state_q == ST_A_WHDR, done_o && res_o.granted, "allocation finish without granted result")
  // a free that rewrites its header reports a result without a grant
  `FFHA_ASSERT_NEXT(a_free_reports, clk_i, rst_ni, state_q == ST_F_WHDR, done_o && !res_o.granted, "free finish without result")
  // a granted payload always sits past its header
  `FFHA_ASSERT(a_payload_past_hdr, clk_i, rst_ni, !(done_o && res_o.granted) || (res_o.payload_address >= AW'(HEADER_BYTES)), "granted payload inside header")

endmodule

`default_nettype wire

[verif/ffha_checker.sv]
// result checker for the first-fit heap allocator: keeps its own granule map and counters,
// predicts each accepted transaction and compares the strobed result; depends on ffha_pkg
`timescale 1ns / 1ps

module ffha_checker import ffha_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  cmd_t        cmd_i,
  input  logic        done_i,
  input  res_t        res_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned grants_o,
  output int unsigned refusals_o,
  output int unsigned releases_o,
  output int unsigned ignored_o
);

  map_t        gran_map [MAP_DEPTH];
  logic [31:0] live_blocks;
  logic [31:0] live_bytes;
  res_t        heap_status_q [$];
  res_t        want;

  task automatic clear_heap();
    for (int i = 0; i < MAP_DEPTH; i++) gran_map[i] = MAP_NONE;
    gran_map[0] = MAP_START;
    live_blocks = '0;
    live_bytes  = 32'(HEADER_BYTES);
  endtask

  // byte offset of the first block start after granule g, or the arena end
  function automatic int unsigned next_boundary(int unsigned g);
    for (int unsigned i = g + 1; i < MAP_DEPTH; i++) begin
      if (gran_map[i][0]) return i * GRANULE_BYTES;
    end
    return ARENA_BYTES;
  endfunction

  function automatic res_t apply_heap_cmd(cmd_t c);
    res_t        r;
    int unsigned size, pos, g, nxt, cut, addr, hdr;
    bit          found, prev_free, valid;
    r = '0;
    if (c.command == CMD_ALLOC) begin
      size  = (32'(c.request_bytes) + ALIGN_BYTES - 1) & ~(ALIGN_BYTES - 1);
      pos   = 0;
      found = 1'b0;
      while (pos < ARENA_BYTES && !found) begin
        g   = pos / GRANULE_BYTES;
        nxt = next_boundary(g);
        if (!gran_map[g][1] && (nxt - pos) >= size + HEADER_BYTES) begin
          cut = pos + HEADER_BYTES + size;
          // split only when the leftover holds more than a bare header
          if ((nxt - pos) > size + 2 * HEADER_BYTES && (cut % GRANULE_BYTES) == 0) begin
            gran_map[cut / GRANULE_BYTES] = MAP_START;
            live_bytes += 32'(HEADER_BYTES);
          end
          gran_map[g]       = MAP_USED_BLK;
          live_blocks      += 1;
          live_bytes       += 32'(size);
          r.granted         = 1'b1;
          r.payload_address = AW'(pos + HEADER_BYTES);
          found             = 1'b1;
        end else begin
          pos = nxt;
        end
      end
      if (found) grants_o++;
      else refusals_o++;
    end else begin
      addr  = c.block_address;
      valid = 1'b0;
      if (addr >= HEADER_BYTES && addr <= ARENA_BYTES) begin
        hdr = addr - HEADER_BYTES;
        if ((hdr % GRANULE_BYTES) == 0 && (hdr / GRANULE_BYTES) < MAP_DEPTH) begin
          g     = hdr / GRANULE_BYTES;
          valid = (gran_map[g] == MAP_USED_BLK);
        end
      end
      if (valid) begin
        nxt = next_boundary(g);
        if (nxt < ARENA_BYTES && !gran_map[nxt / GRANULE_BYTES][1])
          gran_map[nxt / GRANULE_BYTES] = MAP_NONE;
        prev_free = 1'b0;
        for (int i = int'(g) - 1; i >= 0; i--) begin
          if (gran_map[i][0]) begin
            prev_free = !gran_map[i][1];
            break;
          end
        end
        gran_map[g]  = prev_free ? MAP_NONE : MAP_START;
        live_blocks -= 1;
        // span measured before the merge, header included
        live_bytes  -= 32'(nxt - hdr);
        releases_o++;
      end else begin
        ignored_o++;
      end
    end
    r.used_blocks = live_blocks;
    r.used_bytes  = live_bytes;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_heap();
      heap_status_q.delete();
      fail_count_o = 0;
      grants_o     = 0;
      refusals_o   = 0;
      releases_o   = 0;
      ignored_o    = 0;
    end else begin
      if (done_i) begin
        if (heap_status_q.size() == 0) begin
          $display("%0t: result with no transaction pending: granted %0b addr %0d",
                   $time, res_i.granted, res_i.payload_address);
          fail_count_o++;
        end else begin
          want = heap_status_q.pop_front();
          if (res_i.granted !== want.granted) begin
            $display("%0t: granted expected %0b actual %0b",
                     $time, want.granted, res_i.granted);
            fail_count_o++;
          end
          if (res_i.payload_address !== want.payload_address) begin
            $display("%0t: payload_address expected %0d actual %0d",
                     $time, want.payload_address, res_i.payload_address);
            fail_count_o++;
          end
          if (res_i.used_blocks !== want.used_blocks) begin
            $display("%0t: used_blocks expected %0d actual %0d",
                     $time, want.used_blocks, res_i.used_blocks);
            fail_count_o++;
          end
          if (res_i.used_bytes !== want.used_bytes) begin
            $display("%0t: used_bytes expected %0d actual %0d",
                     $time, want.used_bytes, res_i.used_bytes);
            fail_count_o++;
          end
        end
      end
      if (start_i && !busy_i) heap_status_q.push_back(apply_heap_cmd(cmd_i));
    end
    pending_o = heap_status_q.size();
  end

endmodule

[verif/tb_first_fit_heap_allocator.sv]
// testbench top for first_fit_heap_allocator: clock, reset, directed and random
// allocate/free stimulus and the verdict; depends on ffha_pkg and ffha_checker
`timescale 1ns / 1ps

module tb_first_fit_heap_allocator;
  import ffha_pkg::*;

  localparam int unsigned N_RANDOM     = 1876;
  localparam int unsigned N_PHASES     = 4;
  // worst transaction walks the map once; take twice that plus room for sender gaps
  localparam int unsigned ITEM_CYCLES  = 2 * MAP_DEPTH + 6 + 64;
  localparam int unsigned DRAIN_CYCLES = 2 * MAP_DEPTH + 8;
  localparam int unsigned CYCLE_LIMIT  = 2 * MAP_DEPTH + (N_RANDOM + 64) * ITEM_CYCLES * 4;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  cmd_t        cmd_i;
  logic        done_o;
  res_t        res_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned grants;
  int unsigned refusals;
  int unsigned releases;
  int unsigned ignored;
  int unsigned cycle_cnt;
  int unsigned idle_pct;

  // payload offsets currently held, and recently released ones for double frees
  logic [AW-1:0] live_q [$];
  logic [AW-1:0] stale_q [$];
  cmd_t          directed_q [$];

  first_fit_heap_allocator u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .cmd_i  (cmd_i),
    .done_o (done_o),
    .res_o  (res_o)
  );

  ffha_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .cmd_i        (cmd_i),
    .done_i       (done_o),
    .res_i        (res_o),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .grants_o     (grants),
    .refusals_o   (refusals),
    .releases_o   (releases),
    .ignored_o    (ignored)
  );

  // 2 ns clock
  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // watchdog: a hung walk or a lost strobe ends the run here
  initial cycle_cnt = 0;
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("first_fit_heap_allocator verification failed");
      $finish;
    end
  end

  // harvest granted offsets so the random part can free real blocks
  always @(posedge clk_i) begin
    if (rst_ni && done_o && res_o.granted) live_q.push_back(res_o.payload_address);
  end

  // the unused field of each command carries random bits
  function automatic cmd_t alloc_cmd(int unsigned bytes);
    cmd_t c;
    c.command       = CMD_ALLOC;
    c.request_bytes = RW'(bytes);
    c.block_address = AW'($urandom);
    return c;
  endfunction

  function automatic cmd_t free_cmd(int unsigned addr);
    cmd_t c;
    c.command       = CMD_FREE;
    c.request_bytes = RW'($urandom);
    c.block_address = AW'(addr);
    return c;
  endfunction

  // mostly well-formed traffic: allocations of mixed sizes and frees of held
  // blocks, with a slice of bad or repeated frees as noise
  function automatic cmd_t random_heap_cmd();
    cmd_t        c;
    int unsigned roll;
    int unsigned idx;
    int unsigned sel;
    roll = $urandom_range(99);
    if (roll < 8) begin
      if (stale_q.size() > 0 && $urandom_range(1) == 1)
        c = free_cmd(stale_q[$urandom_range(stale_q.size() - 1)]);
      else
        c = free_cmd($urandom_range(ARENA_BYTES));
    end else if (live_q.size() > 0 && (roll < 45 || (live_q.size() > 48 && roll < 75))) begin
      idx = $urandom_range(live_q.size() - 1);
      c   = free_cmd(live_q[idx]);
      stale_q.push_back(live_q[idx]);
      live_q.delete(idx);
      if (stale_q.size() > 16) void'(stale_q.pop_front());
    end else begin
      sel = $urandom_range(99);
      if (sel < 60)      c = alloc_cmd($urandom_range(64));
      else if (sel < 85) c = alloc_cmd($urandom_range(512, 65));
      else if (sel < 95) c = alloc_cmd($urandom_range(ARENA_BYTES, 513));
      else               c = alloc_cmd($urandom_range(16'hFFFF));
    end
    return c;
  endfunction

  // present one transaction at the falling edge and hold it until accepted;
  // start stays high between back-to-back transactions
  task automatic send_cmd(cmd_t c);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
    @(negedge clk_i);
    start <= 1'b1;
    cmd_i <= c;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic wait_drained();
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    start    = 1'b0;
    cmd_i    = '0;
    rst_ni   = 1'b0;
    idle_pct = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed part: split, rounding, merges in every direction
    directed_q.push_back(alloc_cmd(0));      // header-only block at 12
    directed_q.push_back(alloc_cmd(1));      // rounds to 4, at 24
    directed_q.push_back(alloc_cmd(5));      // rounds to 8, at 40
    directed_q.push_back(alloc_cmd(10));     // rounds to 12, at 60
    directed_q.push_back(free_cmd(24));      // both neighbors used
    directed_q.push_back(free_cmd(40));      // merges into free predecessor
    directed_q.push_back(free_cmd(12));      // absorbs free successor
    directed_q.push_back(free_cmd(60));      // merges both sides
    directed_q.push_back(alloc_cmd(16'hFFFF)); // far too large
    directed_q.push_back(alloc_cmd(4085));   // one granule too large
    directed_q.push_back(alloc_cmd(4084));   // exact fit of the whole arena
    directed_q.push_back(alloc_cmd(0));      // arena full
    directed_q.push_back(free_cmd(12));
    directed_q.push_back(alloc_cmd(4072));   // leftover of exactly one header, no split
    directed_q.push_back(free_cmd(12));
    directed_q.push_back(alloc_cmd(4068));   // split leaves a 16-byte tail block
    directed_q.push_back(alloc_cmd(4));      // tail block fits exactly
    directed_q.push_back(free_cmd(4092));    // last block, no successor
    directed_q.push_back(free_cmd(12));
    directed_q.push_back(free_cmd(0));       // below header size
    directed_q.push_back(free_cmd(11));
    directed_q.push_back(free_cmd(14));      // header off a granule boundary
    directed_q.push_back(free_cmd(4096));    // not a used block start
    directed_q.push_back(free_cmd(4100));    // beyond the arena
    directed_q.push_back(free_cmd(12));      // double free
    foreach (directed_q[i]) send_cmd(directed_q[i]);
    @(negedge clk_i);
    start <= 1'b0;
    wait_drained();
    // directed blocks are all released already
    live_q.delete();

    // random part: no idling, sender idle 52%, no idling, sender idle 36%
    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        1:       idle_pct = 52;
        3:       idle_pct = 36;
        default: idle_pct = 0;
      endcase
      for (int n = 0; n < N_RANDOM / N_PHASES; n++) send_cmd(random_heap_cmd());
    end
    @(negedge clk_i);
    start <= 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("run covered %0d grants, %0d refused allocations, %0d releases",
             grants, refusals, releases);
    $display("and %0d frees with bad or stale offsets, over %0d cycles",
             ignored, cycle_cnt);
    if (fail_count == 0) begin
      $display("first_fit_heap_allocator verification clean");
    end else begin
      $display("first_fit_heap_allocator verification failed");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/ffha_pkg.sv
rtl/ffha_map_ram.sv
rtl/ffha_span_unit.sv
rtl/first_fit_heap_allocator.sv
verif/ffha_checker.sv
verif/tb_first_fit_heap_allocator.sv
